// ===== sv/pn2d_pkg.sv =====
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared constants for the 2D gradient noise block: permutation ROM,
// gradient tables, register map and output limit.
// ----------------------------------------------------------------------------
package pn2d_pkg;

    localparam int RES_W = 16;
    localparam int OUT_W = 16;
    localparam int HASH_W = 8;

    localparam logic [0:0] REG_RESOLUTION = 1'b0;
    localparam logic [RES_W-1:0] RES_RESET = 16'd16;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sd16384;
    localparam logic signed [OUT_W-1:0] DIAG_Q14 = 16'sd11585;
    localparam logic signed [OUT_W-1:0] UNIT_Q14 = 16'sd16384;

    localparam logic [7:0] PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic signed [OUT_W-1:0] grad_x(input logic [2:0] g);
        logic signed [OUT_W-1:0] v;
        unique case (g)
            3'd0, 3'd2: v = DIAG_Q14;
            3'd1, 3'd3: v = -DIAG_Q14;
            3'd4:       v = UNIT_Q14;
            3'd5:       v = -UNIT_Q14;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] grad_y(input logic [2:0] g);
        logic signed [OUT_W-1:0] v;
        unique case (g)
            3'd0, 3'd1: v = DIAG_Q14;
            3'd2, 3'd3: v = -DIAG_Q14;
            3'd6:       v = UNIT_Q14;
            3'd7:       v = -UNIT_Q14;
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/pn2d_fifo.sv =====
// ----------------------------------------------------------------------------
// pn2d_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module pn2d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (w_rd && !w_wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== sv/pn2d_front.sv =====
// ----------------------------------------------------------------------------
// pn2d_front
// Pipelined restoring divider, one quotient bit per stage, for both
// coordinates: gives the low 8 bits of the cell index and the fraction.
// ----------------------------------------------------------------------------
module pn2d_front #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [pn2d_pkg::RES_W-1:0]          i_x_coord,
    input  logic [pn2d_pkg::RES_W-1:0]          i_y_coord,
    input  logic [pn2d_pkg::RES_W-1:0]          i_res,
    input  logic                                i_q_full,
    output logic                                o_push,
    output logic [2*(pn2d_pkg::HASH_W+FRAC_BITS)-1:0] o_data
);

    localparam int CB = COORD_BITS;
    localparam int N  = COORD_BITS + FRAC_BITS;
    localparam int QW = pn2d_pkg::HASH_W + FRAC_BITS;
    localparam int RW = pn2d_pkg::RES_W;

    logic [CB-1:0] r_dx [N];
    logic [CB-1:0] r_dy [N];
    logic [RW-1:0] r_rx [N];
    logic [RW-1:0] r_ry [N];
    logic [QW-1:0] r_qx [N];
    logic [QW-1:0] r_qy [N];
    logic [RW-1:0] r_r  [N];
    logic          r_v  [N];

    logic          w_en;
    logic [RW-1:0] w_res;

    assign w_en    = !(r_v[N-1] && i_q_full);
    assign o_ready = w_en;
    assign o_push  = r_v[N-1] && !i_q_full;
    assign o_data  = {r_qx[N-1], r_qy[N-1]};
    assign w_res   = (i_res == '0) ? RW'(1) : i_res;

    function automatic void div_step(
        input  logic [CB-1:0] d,
        input  logic [RW-1:0] rm,
        input  logic [QW-1:0] q,
        input  logic [RW-1:0] r,
        output logic [CB-1:0] d_n,
        output logic [RW-1:0] rm_n,
        output logic [QW-1:0] q_n
    );
        logic [RW:0] t;
        logic        ge;
        t    = {rm, d[CB-1]};
        ge   = (t >= {1'b0, r});
        d_n  = d << 1;
        rm_n = ge ? RW'(t - {1'b0, r}) : t[RW-1:0];
        q_n  = {q[QW-2:0], ge};
    endfunction

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [CB-1:0] pdx, pdy, ndx, ndy;
        logic [RW-1:0] prx, pry, nrx, nry, pr;
        logic [QW-1:0] pqx, pqy, nqx, nqy;
        logic          pv;

        if (k == 0) begin : g_in
            assign pdx = CB'(i_x_coord);
            assign pdy = CB'(i_y_coord);
            assign prx = '0;
            assign pry = '0;
            assign pqx = '0;
            assign pqy = '0;
            assign pr  = w_res;
            assign pv  = i_valid;
        end else begin : g_mid
            assign pdx = r_dx[k-1];
            assign pdy = r_dy[k-1];
            assign prx = r_rx[k-1];
            assign pry = r_ry[k-1];
            assign pqx = r_qx[k-1];
            assign pqy = r_qy[k-1];
            assign pr  = r_r[k-1];
            assign pv  = r_v[k-1];
        end

        always_comb begin
            div_step(pdx, prx, pqx, pr, ndx, nrx, nqx);
            div_step(pdy, pry, pqy, pr, ndy, nry, nqy);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dx[k] <= ndx;
                r_dy[k] <= ndy;
                r_rx[k] <= nrx;
                r_ry[k] <= nry;
                r_qx[k] <= nqx;
                r_qy[k] <= nqy;
                r_r[k]  <= pr;
            end
        end
    end

endmodule

// ===== sv/pn2d_back.sv =====
// ----------------------------------------------------------------------------
// pn2d_back
// Hash, gradient dot products, fade curves and the two-level blend.
// Six register stages under one stall enable.
// ----------------------------------------------------------------------------
module pn2d_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic [2*(pn2d_pkg::HASH_W+FRAC_BITS)-1:0] i_data,
    output logic                                      o_take,
    input  logic                                      i_out_full,
    output logic                                      o_push,
    output logic [pn2d_pkg::OUT_W-1:0]                o_noise
);

    localparam int F  = FRAC_BITS;
    localparam int QW = pn2d_pkg::HASH_W + F;
    localparam int DW = 18;
    localparam int LW = 20;
    localparam int PW = F + DW;
    localparam int LP = F + LW + 3;
    localparam int OW = pn2d_pkg::OUT_W;

    localparam logic [2*F:0]           HALF_U = (2*F+1)'(1) << (F-1);
    localparam logic [2*F+1:0]         HALF_U2 = (2*F+2)'(1) << (F-1);
    localparam logic signed [PW-1:0]   HALF_P = PW'(1) << (F-1);
    localparam logic signed [LP-1:0]   HALF_L = LP'(1) << (F-1);
    localparam logic signed [F+3:0]    ONE_C = (F+4)'(1) << F;

    logic w_en;

    // stage 1
    logic         r1_v;
    logic [7:0]   r1_ii, r1_jj;
    logic [F-1:0] r1_f [2];
    // stage 2
    logic         r2_v;
    logic [7:0]   r2_ii, r2_rj0, r2_rj1;
    logic [F-1:0] r2_f [2];
    logic [F:0]   r2_f2 [2];
    // stage 3
    logic         r3_v;
    logic [7:0]   r3_h [4];
    logic [F-1:0] r3_f [2];
    logic [F:0]   r3_f2 [2];
    logic [F:0]   r3_f3 [2];
    // stage 4
    logic                 r4_v;
    logic signed [DW-1:0] r4_d [4];
    logic [F:0]           r4_w [2];
    // stage 5
    logic                 r5_v;
    logic signed [LW-1:0] r5_l1, r5_l2;
    logic [F:0]           r5_wy;
    // stage 6
    logic                 r6_v;
    logic [OW-1:0]        r6_n;

    logic [F:0]           n2_f2 [2];
    logic [F:0]           n3_f3 [2];
    logic [7:0]           n3_h [4];
    logic signed [DW-1:0] n4_d [4];
    logic [F:0]           n4_w [2];
    logic signed [LW-1:0] n5_l1, n5_l2;
    logic [OW-1:0]        n6_n;

    assign w_en    = !(r6_v && i_out_full);
    assign o_take  = w_en && i_valid;
    assign o_push  = r6_v && !i_out_full;
    assign o_noise = r6_n;

    always_comb begin
        logic [2*F:0]   sq;
        logic [2*F+1:0] cu;
        for (int i = 0; i < 2; i++) begin
            sq       = (2*F+1)'(r1_f[i]) * (2*F+1)'(r1_f[i]) + HALF_U;
            n2_f2[i] = sq[2*F:F];
            cu       = (2*F+2)'(r2_f2[i]) * (2*F+2)'(r2_f[i]) + HALF_U2;
            n3_f3[i] = cu[2*F:F];
        end
    end

    always_comb begin
        n3_h[0] = pn2d_pkg::PERM[8'(r2_ii + r2_rj0)];
        n3_h[1] = pn2d_pkg::PERM[8'(r2_ii + 8'd1 + r2_rj0)];
        n3_h[2] = pn2d_pkg::PERM[8'(r2_ii + r2_rj1)];
        n3_h[3] = pn2d_pkg::PERM[8'(r2_ii + 8'd1 + r2_rj1)];
    end

    always_comb begin
        logic signed [F:0]    dx, dy;
        logic signed [OW-1:0] gx, gy;
        logic signed [PW-1:0] pd, sh;
        logic signed [F+3:0]  cv;
        for (int c = 0; c < 4; c++) begin
            dx      = (c % 2 == 1) ? {1'b1, r3_f[0]} : {1'b0, r3_f[0]};
            dy      = (c / 2 == 1) ? {1'b1, r3_f[1]} : {1'b0, r3_f[1]};
            gx      = pn2d_pkg::grad_x(r3_h[c][2:0]);
            gy      = pn2d_pkg::grad_y(r3_h[c][2:0]);
            pd      = gx * dx + gy * dy + HALF_P;
            sh      = pd >>> F;
            n4_d[c] = sh[DW-1:0];
        end
        for (int i = 0; i < 2; i++) begin
            cv = $signed({3'b000, r3_f2[i]}) + $signed({2'b00, r3_f2[i], 1'b0})
                 - $signed({2'b00, r3_f3[i], 1'b0});
            if (cv < 0) n4_w[i] = '0;
            else if (cv > ONE_C) n4_w[i] = ONE_C[F:0];
            else n4_w[i] = cv[F:0];
        end
    end

    always_comb begin
        logic signed [LW:0]   df1, df2;
        logic signed [F+1:0]  cs;
        logic signed [LP-1:0] p1, p2, s1, s2;
        cs    = $signed({1'b0, r4_w[0]});
        df1   = r4_d[1] - r4_d[0];
        df2   = r4_d[3] - r4_d[2];
        p1    = cs * df1 + HALF_L;
        p2    = cs * df2 + HALF_L;
        s1    = p1 >>> F;
        s2    = p2 >>> F;
        n5_l1 = r4_d[0] + $signed(s1[LW-1:0]);
        n5_l2 = r4_d[2] + $signed(s2[LW-1:0]);
    end

    always_comb begin
        logic signed [LW:0]   df;
        logic signed [F+1:0]  cs;
        logic signed [LP-1:0] p, s;
        logic signed [LW-1:0] n;
        cs = $signed({1'b0, r5_wy});
        df = r5_l2 - r5_l1;
        p  = cs * df + HALF_L;
        s  = p >>> F;
        n  = r5_l1 + $signed(s[LW-1:0]);
        if (n > LW'(pn2d_pkg::OUT_MAX)) n6_n = pn2d_pkg::OUT_MAX;
        else if (n < -LW'(pn2d_pkg::OUT_MAX)) n6_n = -pn2d_pkg::OUT_MAX;
        else n6_n = n[OW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ii   <= i_data[2*QW-1:QW+F];
            r1_f[0] <= i_data[QW+F-1:QW];
            r1_jj   <= i_data[QW-1:F];
            r1_f[1] <= i_data[F-1:0];

            r2_ii   <= r1_ii;
            r2_rj0  <= pn2d_pkg::PERM[r1_jj];
            r2_rj1  <= pn2d_pkg::PERM[8'(r1_jj + 8'd1)];
            r2_f    <= r1_f;
            r2_f2   <= n2_f2;

            r3_h    <= n3_h;
            r3_f    <= r2_f;
            r3_f2   <= r2_f2;
            r3_f3   <= n3_f3;

            r4_d    <= n4_d;
            r4_w    <= n4_w;

            r5_l1   <= n5_l1;
            r5_l2   <= n5_l2;
            r5_wy   <= r4_w[1];

            r6_n    <= n6_n;
        end
    end

endmodule

// ===== sv/perlin_noise_2d_top.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_2d_top
// 2D gradient noise: one signed Q1.14 value per (x, y) point.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a point is taken at a clock edge with
// push high and full low. Result side is a queue read port: the oldest noise
// value sits on o_noise while empty is low and leaves on an edge with pop high.
// The APB port holds the resolution register at address 0 (reset value 16,
// zero acts as one); write it only while no point is in flight.
// Throughput is one point per cycle while the reader keeps up. A point passes
// through the divider pipeline, which yields one quotient bit per stage, then
// the six-stage hash/blend pipeline and two queue hops.
// A stalled reader fills the output queue; the blend pipeline then holds,
// the middle queue fills, the divider holds and full rises. Nothing is lost.
// Synchronous reset empties both queues and clears all stage valid bits.
// ----------------------------------------------------------------------------
module perlin_noise_2d_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_x_coord,
    input  logic [15:0] i_y_coord,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_noise,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QW = pn2d_pkg::HASH_W + FRAC_BITS;
    localparam int RW = pn2d_pkg::RES_W;
    localparam int OW = pn2d_pkg::OUT_W;

    logic [RW-1:0]     r_res;
    logic              w_wr;
    logic              w_fr_ready, w_fr_push, w_mid_full, w_mid_empty, w_take;
    logic [2*QW-1:0]   w_fr_data, w_mid_data;
    logic              w_bk_push, w_out_full;
    logic [OW-1:0]     w_bk_noise;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == pn2d_pkg::REG_RESOLUTION);
    assign prdata = (paddr[2] == pn2d_pkg::REG_RESOLUTION) ? {16'b0, r_res} : '0;
    assign full   = !w_fr_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= pn2d_pkg::RES_RESET;
        end else if (w_wr) begin
            r_res <= pwdata[RW-1:0];
        end
    end

    pn2d_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (push),
        .o_ready   (w_fr_ready),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .i_res     (r_res),
        .i_q_full  (w_mid_full),
        .o_push    (w_fr_push),
        .o_data    (w_fr_data)
    );

    pn2d_fifo #(.WIDTH(2*QW), .DEPTH(4)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_push),
        .i_data  (w_fr_data),
        .o_full  (w_mid_full),
        .i_pop   (w_take),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty)
    );

    pn2d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_mid_empty),
        .i_data     (w_mid_data),
        .o_take     (w_take),
        .i_out_full (w_out_full),
        .o_push     (w_bk_push),
        .o_noise    (w_bk_noise)
    );

    pn2d_fifo #(.WIDTH(OW), .DEPTH(4)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_bk_push),
        .i_data  (w_bk_noise),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_noise),
        .o_empty (empty)
    );

`ifndef SYNTHESIS
    a_front_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_mid_full |-> !full)
        else $error("front stalled with room in middle queue");

    a_res_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (r_res == $past(pwdata[RW-1:0])))
        else $error("resolution write lost");

    a_noise_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ($signed(o_noise) <= pn2d_pkg::OUT_MAX &&
                    $signed(o_noise) >= -pn2d_pkg::OUT_MAX))
        else $error("noise out of range");
`endif

endmodule
